// ===== sv/motion_command_relative_terminator_assert.svh =====
// assertion macros for the motion command unit
// expects i_clk and i_rst_n in the scope of the including module
`ifndef MOTION_COMMAND_RELATIVE_TERMINATOR_ASSERT_SVH
`define MOTION_COMMAND_RELATIVE_TERMINATOR_ASSERT_SVH

// antecedent in this cycle implies consequent in the same cycle
`define MCRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define MCRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mcrt_pkg.sv =====
// types and constants for the motion command unit with relative-move terminators
// no dependencies
package mcrt_pkg;

    // command and sample codes carried in tuser
    typedef enum logic [3:0] {
        OP_POSE          = 4'd0,
        OP_KILL          = 4'd1,
        OP_FIND_INDEX    = 4'd2,
        OP_ROT_HALT      = 4'd3,
        OP_ROT_REL_NEG   = 4'd4,
        OP_ROT_REL_POS   = 4'd5,
        OP_ROT_VEL_NEG   = 4'd6,
        OP_ROT_VEL_POS   = 4'd7,
        OP_SET_RVEL      = 4'd8,
        OP_SET_TVEL      = 4'd9,
        OP_TRANS_HALT    = 4'd10,
        OP_TRANS_REL_NEG = 4'd11,
        OP_TRANS_REL_POS = 4'd12,
        OP_TRANS_VEL_NEG = 4'd13,
        OP_TRANS_VEL_POS = 4'd14,
        OP_NONE          = 4'd15
    } t_opcode;

    // direction codes, two bit signed
    localparam logic signed [1:0] SIGN_NEG  = -2'sd1;
    localparam logic signed [1:0] SIGN_ZERO = 2'sd0;
    localparam logic signed [1:0] SIGN_POS  = 2'sd1;

    // angle constants in degrees q.8
    localparam int DEG8_Q8   = 2048;
    localparam int DEG30_Q8  = 7680;
    localparam int DEG180_Q8 = 46080;
    localparam int DEG360_Q8 = 92160;

    // 1024ths of a turn to degrees q.8, and the 0.733 scale in unsigned q.16
    localparam int ROT_SCALE      = 90;
    localparam int K0733_Q16      = 48038;
    localparam int ROUND_HALF_Q16 = 32768;

    // field widths
    localparam int PARAM_W   = 16;
    localparam int POS_W     = 23;
    localparam int HEAD_W    = 18;
    localparam int ROTGOAL_W = 22;
    localparam int IN_DATA_W = 80;
    localparam int OUT_DATA_W = 40;

    // result item, first field in the highest bits
    typedef struct packed {
        logic                      move_done;
        logic                      rvel_changed;
        logic signed [1:0]         rvel_direction;
        logic signed [PARAM_W-1:0] rvel_value;
        logic                      tvel_changed;
        logic signed [1:0]         tvel_direction;
        logic signed [PARAM_W-1:0] tvel_value;
    } t_result;

endpackage

// ===== sv/motion_command_relative_terminator.sv =====
// motion command unit: velocity settings plus translate and rotate move terminators
// depends on mcrt_pkg and motion_command_relative_terminator_assert.svh

// Takes one transaction per clock while s_axis_tready is high and returns exactly one
// result transaction for each: an input register holds the item, a single pass of logic
// updates the velocity, sign and terminator state from it, and a result register drives
// the master side. Throughput is one item per cycle unless the output stalls, set by
// that single state update pass (two 23x23 squarers for the distance check, a seven-way
// heading wrap and a saturating accumulator). The input register keeps accepting while
// a result waits to be taken; s_axis_tready drops only when both registers are full.
// ACCUM_BITS sets the width of the saturating heading-change accumulator.
module motion_command_relative_terminator #(
    parameter int ACCUM_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // param[15:0], pos_x_mm[38:16], pos_y_mm[61:39], heading_deg_q8[79:62]
    input  logic [mcrt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // opcode[3:0]
    input  logic [3:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tvel_value[15:0], tvel_direction[17:16], tvel_changed[18], rvel_value[34:19],
    // rvel_direction[36:35], rvel_changed[37], move_done[38], zero[39]
    output logic [mcrt_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    import mcrt_pkg::*;

    localparam int CMP_W = (ACCUM_BITS > ROTGOAL_W) ? ACCUM_BITS : ROTGOAL_W;
    localparam logic [ACCUM_BITS-1:0] ACCUM_MAX = {ACCUM_BITS{1'b1}};
    localparam logic signed [20:0] HALF_TURN = 21'(DEG180_Q8);
    localparam logic signed [20:0] FULL_TURN = 21'(DEG360_Q8);

    // input register
    logic                      r_in_valid;
    t_opcode                   r_op;
    logic signed [PARAM_W-1:0] r_param;
    logic signed [POS_W-1:0]   r_px;
    logic signed [POS_W-1:0]   r_py;
    logic signed [HEAD_W-1:0]  r_ph;

    // result register
    logic    r_out_valid;
    t_result r_res;
    t_result n_res;

    // velocity and terminator state
    logic signed [PARAM_W-1:0] r_tvel, n_tvel;
    logic signed [1:0]         r_tsign, n_tsign;
    logic signed [PARAM_W-1:0] r_rvel, n_rvel;
    logic signed [1:0]         r_rsign, n_rsign;
    logic                      r_trans_armed, n_trans_armed;
    logic                      r_trans_active, n_trans_active;
    logic signed [POS_W-1:0]   r_origin_x, n_origin_x;
    logic signed [POS_W-1:0]   r_origin_y, n_origin_y;
    logic                      r_goal_nonpos, n_goal_nonpos;
    logic [29:0]               r_goal_sq, n_goal_sq;
    logic                      r_rot_armed, n_rot_armed;
    logic                      r_rot_active, n_rot_active;
    logic signed [HEAD_W-1:0]  r_prev_head, n_prev_head;
    logic [ACCUM_BITS-1:0]     r_turned, n_turned;
    logic [ROTGOAL_W-1:0]      r_rot_goal, n_rot_goal;

    logic advance;

    // handshake: the input register refills whenever its item moves on
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_res};

    // distance check from the captured origin
    logic signed [POS_W:0] dx, dy;
    logic [POS_W-1:0]      ax, ay;
    logic [2*POS_W-1:0]    sq_x, sq_y;
    logic [2*POS_W:0]      dist_sq;
    logic                  trans_hit;

    always_comb begin
        dx        = (POS_W+1)'(r_px) - (POS_W+1)'(r_origin_x);
        dy        = (POS_W+1)'(r_py) - (POS_W+1)'(r_origin_y);
        ax        = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
        ay        = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
        sq_x      = (2*POS_W)'(ax) * (2*POS_W)'(ax);
        sq_y      = (2*POS_W)'(ay) * (2*POS_W)'(ay);
        dist_sq   = (2*POS_W+1)'(sq_x) + (2*POS_W+1)'(sq_y);
        trans_hit = r_goal_nonpos || (dist_sq >= (2*POS_W+1)'(r_goal_sq));
    end

    // heading change wrapped into (-180, 180] degrees, then its magnitude accumulated
    logic signed [20:0]      head_diff;
    logic signed [20:0]      cand;
    logic signed [20:0]      wrapped;
    logic [15:0]             abs_turn;
    logic [ACCUM_BITS:0]     turn_sum;
    logic [ACCUM_BITS-1:0]   turn_sat;
    logic                    rot_hit;

    always_comb begin
        head_diff = 21'(r_prev_head) - 21'(r_ph);
        wrapped   = '0;
        cand      = '0;
        for (int k = -3; k <= 3; k++) begin
            cand = head_diff + 21'(k) * FULL_TURN;
            if (cand > -HALF_TURN && cand <= HALF_TURN) begin
                wrapped = cand;
            end
        end
        abs_turn = wrapped[20] ? 16'(-wrapped) : wrapped[15:0];
        turn_sum = (ACCUM_BITS+1)'(r_turned) + (ACCUM_BITS+1)'(abs_turn);
        turn_sat = turn_sum[ACCUM_BITS] ? ACCUM_MAX : turn_sum[ACCUM_BITS-1:0];
        rot_hit  = CMP_W'(turn_sat) >= CMP_W'(r_rot_goal);
    end

    // rotate goal: 1024ths of a turn to degrees q.8, then trim or 0.733 scale
    logic [PARAM_W-1:0]   abs_param;
    logic [ROTGOAL_W-1:0] rot_mag;
    logic [29:0]          rot_small;
    logic [ROTGOAL_W-1:0] rot_goal_cmd;
    logic [29:0]          goal_sq_cmd;

    always_comb begin
        abs_param = r_param[PARAM_W-1] ? PARAM_W'(-r_param) : r_param;
        rot_mag   = ROTGOAL_W'(abs_param) * ROTGOAL_W'(ROT_SCALE);
        rot_small = 30'(rot_mag[12:0]) * 30'(K0733_Q16) + 30'(ROUND_HALF_Q16);
        if (rot_mag > ROTGOAL_W'(DEG30_Q8)) begin
            rot_goal_cmd = rot_mag - ROTGOAL_W'(DEG8_Q8);
        end else begin
            rot_goal_cmd = ROTGOAL_W'(rot_small[29:16]);
        end
        goal_sq_cmd = 30'(r_param[14:0]) * 30'(r_param[14:0]);
    end

    // next state and result for the item in the input register
    logic fired;

    always_comb begin
        n_tvel         = r_tvel;
        n_tsign        = r_tsign;
        n_rvel         = r_rvel;
        n_rsign        = r_rsign;
        n_trans_armed  = r_trans_armed;
        n_trans_active = r_trans_active;
        n_origin_x     = r_origin_x;
        n_origin_y     = r_origin_y;
        n_goal_nonpos  = r_goal_nonpos;
        n_goal_sq      = r_goal_sq;
        n_rot_armed    = r_rot_armed;
        n_rot_active   = r_rot_active;
        n_prev_head    = r_prev_head;
        n_turned       = r_turned;
        n_rot_goal     = r_rot_goal;
        n_res          = '0;
        fired          = 1'b0;

        unique case (r_op)
            OP_POSE: begin
                if (r_trans_armed) begin
                    n_origin_x     = r_px;
                    n_origin_y     = r_py;
                    n_trans_active = 1'b1;
                    n_trans_armed  = 1'b0;
                end else if (r_trans_active && trans_hit) begin
                    fired          = 1'b1;
                    n_trans_active = 1'b0;
                end
                if (r_rot_armed) begin
                    n_prev_head  = r_ph;
                    n_turned     = '0;
                    n_rot_active = 1'b1;
                    n_rot_armed  = 1'b0;
                end else if (r_rot_active) begin
                    n_turned    = turn_sat;
                    n_prev_head = r_ph;
                    if (rot_hit) begin
                        fired        = 1'b1;
                        n_rot_active = 1'b0;
                    end
                end
                if (fired) begin
                    n_tsign              = SIGN_ZERO;
                    n_rsign              = SIGN_ZERO;
                    n_res.tvel_changed   = 1'b1;
                    n_res.rvel_changed   = 1'b1;
                    n_res.move_done      = 1'b1;
                end
            end
            OP_KILL: begin
                n_tvel             = '0;
                n_rvel             = '0;
                n_tsign            = SIGN_ZERO;
                n_rsign            = SIGN_ZERO;
                n_res.tvel_changed = 1'b1;
                n_res.rvel_changed = 1'b1;
            end
            OP_FIND_INDEX: begin
                n_rvel             = '0;
                n_rsign            = SIGN_ZERO;
                n_res.rvel_changed = 1'b1;
            end
            OP_ROT_HALT: begin
                n_rsign            = SIGN_ZERO;
                n_res.rvel_changed = 1'b1;
            end
            OP_ROT_REL_NEG, OP_ROT_REL_POS: begin
                n_tsign            = SIGN_ZERO;
                n_rsign            = (r_op == OP_ROT_REL_NEG) ? SIGN_NEG : SIGN_POS;
                n_res.tvel_changed = 1'b1;
                n_res.rvel_changed = 1'b1;
                n_rot_goal         = rot_goal_cmd;
                n_rot_armed        = 1'b1;
            end
            OP_ROT_VEL_NEG: begin
                n_rsign            = SIGN_NEG;
                n_res.rvel_changed = 1'b1;
            end
            OP_ROT_VEL_POS: begin
                n_rsign            = SIGN_POS;
                n_res.rvel_changed = 1'b1;
            end
            OP_SET_RVEL: begin
                n_rvel             = r_param;
                n_res.rvel_changed = 1'b1;
            end
            OP_SET_TVEL: begin
                n_tvel             = r_param;
                n_res.tvel_changed = 1'b1;
            end
            OP_TRANS_HALT: begin
                n_tsign            = SIGN_ZERO;
                n_res.tvel_changed = 1'b1;
            end
            OP_TRANS_REL_NEG, OP_TRANS_REL_POS: begin
                n_tsign            = (r_op == OP_TRANS_REL_NEG) ? SIGN_NEG : SIGN_POS;
                n_rsign            = SIGN_ZERO;
                n_res.tvel_changed = 1'b1;
                n_res.rvel_changed = 1'b1;
                n_goal_nonpos      = r_param[PARAM_W-1] || (r_param == '0);
                n_goal_sq          = goal_sq_cmd;
                n_trans_armed      = 1'b1;
            end
            OP_TRANS_VEL_NEG: begin
                n_tsign            = SIGN_NEG;
                n_res.tvel_changed = 1'b1;
            end
            OP_TRANS_VEL_POS: begin
                n_tsign            = SIGN_POS;
                n_res.tvel_changed = 1'b1;
            end
            OP_NONE: begin
            end
        endcase

        n_res.tvel_value     = n_tvel;
        n_res.tvel_direction = n_tsign;
        n_res.rvel_value     = n_rvel;
        n_res.rvel_direction = n_rsign;
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_tvel         <= '0;
            r_tsign        <= SIGN_ZERO;
            r_rvel         <= '0;
            r_rsign        <= SIGN_ZERO;
            r_trans_armed  <= 1'b0;
            r_trans_active <= 1'b0;
            r_origin_x     <= '0;
            r_origin_y     <= '0;
            r_goal_nonpos  <= 1'b1;
            r_goal_sq      <= '0;
            r_rot_armed    <= 1'b0;
            r_rot_active   <= 1'b0;
            r_prev_head    <= '0;
            r_turned       <= '0;
            r_rot_goal     <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid    <= 1'b1;
                r_tvel         <= n_tvel;
                r_tsign        <= n_tsign;
                r_rvel         <= n_rvel;
                r_rsign        <= n_rsign;
                r_trans_armed  <= n_trans_armed;
                r_trans_active <= n_trans_active;
                r_origin_x     <= n_origin_x;
                r_origin_y     <= n_origin_y;
                r_goal_nonpos  <= n_goal_nonpos;
                r_goal_sq      <= n_goal_sq;
                r_rot_armed    <= n_rot_armed;
                r_rot_active   <= n_rot_active;
                r_prev_head    <= n_prev_head;
                r_turned       <= n_turned;
                r_rot_goal     <= n_rot_goal;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op    <= t_opcode'(s_axis_tuser);
            r_param <= s_axis_tdata[15:0];
            r_px    <= s_axis_tdata[38:16];
            r_py    <= s_axis_tdata[61:39];
            r_ph    <= s_axis_tdata[79:62];
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    // checks on the pipeline and the terminator outputs
`include "motion_command_relative_terminator_assert.svh"

    `MCRT_ASSERT_NOW(a_done_stops, r_out_valid && r_res.move_done, r_res.tvel_direction == SIGN_ZERO && r_res.rvel_direction == SIGN_ZERO && r_res.tvel_changed && r_res.rvel_changed, "move done without both signs stopped")
    `MCRT_ASSERT_NEXT(a_cmd_no_done, advance && r_op != OP_POSE, !r_res.move_done, "move done raised on a command")
    `MCRT_ASSERT_NOW(a_stall_full, !s_axis_tready, r_in_valid && r_out_valid && !m_axis_tready, "input stalled with room to spare")

endmodule

// ===== tb/motion_command_relative_terminator_test.sv =====
// self-checking testbench for the motion command unit with relative-move terminators
// depends on mcrt_pkg and motion_command_relative_terminator; an internal predictor
// gives the expected result transaction for every command and pose sample sent
module motion_command_relative_terminator_test;
    import mcrt_pkg::*;

    localparam int TURN_BITS      = 24;
    localparam longint TURN_SUM_MAX = (64'sd1 <<< TURN_BITS) - 1;
    localparam int QUIET_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int PHASE_ITEMS    = 250;
    localparam int POS_MIN        = -4194304;
    localparam int POS_MAX        = 4194303;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // param[15:0], pos_x_mm[38:16], pos_y_mm[61:39], heading_deg_q8[79:62]
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    // opcode[3:0]
    logic [3:0]             s_axis_tuser = OP_NONE;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tvel_value[15:0], tvel_direction[17:16], tvel_changed[18], rvel_value[34:19],
    // rvel_direction[36:35], rvel_changed[37], move_done[38], zero[39]
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    // traffic shaping shared between the sender, the receiver and the tests
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_off_cycles = 0;
    int hold_off_left   = 0;
    int quiet_cycles    = 0;
    int items_sent      = 0;
    int errors          = 0;

    t_result motion_expect_q[$];

    // predicted block state, all zero out of reset
    logic signed [PARAM_W-1:0]   trans_speed   = '0;
    logic signed [1:0]           trans_dir     = SIGN_ZERO;
    logic signed [PARAM_W-1:0]   rot_speed     = '0;
    logic signed [1:0]           rot_dir       = SIGN_ZERO;
    logic                        dist_pending  = 1'b0;
    logic                        dist_running  = 1'b0;
    logic signed [POS_W-1:0]     start_x       = '0;
    logic signed [POS_W-1:0]     start_y       = '0;
    logic signed [PARAM_W-1:0]   dist_target   = '0;
    logic                        turn_pending  = 1'b0;
    logic                        turn_running  = 1'b0;
    logic signed [HEAD_W-1:0]    last_heading  = '0;
    logic [TURN_BITS-1:0]        turn_sum      = '0;
    logic [ROTGOAL_W-1:0]        turn_target   = '0;

    motion_command_relative_terminator #(
        .ACCUM_BITS(TURN_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // update the predicted state with one item and return the result it gives
    function automatic t_result apply_motion_item(input t_opcode op,
                                                  input logic signed [PARAM_W-1:0] prm,
                                                  input logic signed [POS_W-1:0] px,
                                                  input logic signed [POS_W-1:0] py,
                                                  input logic signed [HEAD_W-1:0] ph);
        t_result res;
        logic    tch;
        logic    rch;
        logic    fired;
        longint  dx;
        longint  dy;
        longint  wrap;
        longint  sum;
        longint  mag;
        longint  goal;
        tch   = 1'b0;
        rch   = 1'b0;
        fired = 1'b0;
        case (op)
            OP_POSE: begin
                // translate terminator checked before rotate
                if (dist_pending) begin
                    start_x      = px;
                    start_y      = py;
                    dist_running = 1'b1;
                    dist_pending = 1'b0;
                end else if (dist_running) begin
                    dx = longint'(px) - longint'(start_x);
                    dy = longint'(py) - longint'(start_y);
                    if (dist_target <= 0 ||
                        dx * dx + dy * dy >= longint'(dist_target) * longint'(dist_target)) begin
                        fired        = 1'b1;
                        dist_running = 1'b0;
                    end
                end
                if (turn_pending) begin
                    last_heading = ph;
                    turn_sum     = '0;
                    turn_running = 1'b1;
                    turn_pending = 1'b0;
                end else if (turn_running) begin
                    // heading change wrapped into (-180, 180] degrees
                    wrap = (longint'(last_heading) - longint'(ph)) % DEG360_Q8;
                    if (wrap < 0) wrap = wrap + DEG360_Q8;
                    if (wrap > DEG180_Q8) wrap = wrap - DEG360_Q8;
                    if (wrap < 0) wrap = -wrap;
                    sum = longint'(turn_sum) + wrap;
                    if (sum > TURN_SUM_MAX) sum = TURN_SUM_MAX;
                    turn_sum     = sum[TURN_BITS-1:0];
                    last_heading = ph;
                    if (turn_sum >= turn_target) begin
                        fired        = 1'b1;
                        turn_running = 1'b0;
                    end
                end
                if (fired) begin
                    trans_dir = SIGN_ZERO;
                    rot_dir   = SIGN_ZERO;
                    tch       = 1'b1;
                    rch       = 1'b1;
                end
            end
            OP_KILL: begin
                trans_speed = '0;
                rot_speed   = '0;
                trans_dir   = SIGN_ZERO;
                rot_dir     = SIGN_ZERO;
                tch         = 1'b1;
                rch         = 1'b1;
            end
            OP_FIND_INDEX: begin
                rot_speed = '0;
                rot_dir   = SIGN_ZERO;
                rch       = 1'b1;
            end
            OP_ROT_HALT: begin
                rot_dir = SIGN_ZERO;
                rch     = 1'b1;
            end
            OP_ROT_REL_NEG, OP_ROT_REL_POS: begin
                // goal: less 8 degrees above 30 degrees, else scaled by 0.733
                mag = longint'(prm);
                if (mag < 0) mag = -mag;
                mag = mag * ROT_SCALE;
                if (mag > DEG30_Q8)
                    goal = mag - DEG8_Q8;
                else
                    goal = (mag * K0733_Q16 + ROUND_HALF_Q16) >>> 16;
                turn_target  = goal[ROTGOAL_W-1:0];
                trans_dir    = SIGN_ZERO;
                rot_dir      = (op == OP_ROT_REL_NEG) ? SIGN_NEG : SIGN_POS;
                tch          = 1'b1;
                rch          = 1'b1;
                turn_pending = 1'b1;
            end
            OP_ROT_VEL_NEG: begin
                rot_dir = SIGN_NEG;
                rch     = 1'b1;
            end
            OP_ROT_VEL_POS: begin
                rot_dir = SIGN_POS;
                rch     = 1'b1;
            end
            OP_SET_RVEL: begin
                rot_speed = prm;
                rch       = 1'b1;
            end
            OP_SET_TVEL: begin
                trans_speed = prm;
                tch         = 1'b1;
            end
            OP_TRANS_HALT: begin
                trans_dir = SIGN_ZERO;
                tch       = 1'b1;
            end
            OP_TRANS_REL_NEG, OP_TRANS_REL_POS: begin
                trans_dir    = (op == OP_TRANS_REL_NEG) ? SIGN_NEG : SIGN_POS;
                rot_dir      = SIGN_ZERO;
                tch          = 1'b1;
                rch          = 1'b1;
                dist_target  = prm;
                dist_pending = 1'b1;
            end
            OP_TRANS_VEL_NEG: begin
                trans_dir = SIGN_NEG;
                tch       = 1'b1;
            end
            OP_TRANS_VEL_POS: begin
                trans_dir = SIGN_POS;
                tch       = 1'b1;
            end
            default: begin
            end
        endcase
        res.tvel_value     = trans_speed;
        res.tvel_direction = trans_dir;
        res.tvel_changed   = tch;
        res.rvel_value     = rot_speed;
        res.rvel_direction = rot_dir;
        res.rvel_changed   = rch;
        res.move_done      = fired;
        return res;
    endfunction

    function automatic int rand_span(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int rand_heading();
        return rand_span(-DEG360_Q8, DEG360_Q8);
    endfunction

    // offer one item, wait for its transaction and record the expected result
    task automatic send_item(input t_opcode op,
                             input logic signed [PARAM_W-1:0] prm,
                             input logic signed [POS_W-1:0] px,
                             input logic signed [POS_W-1:0] py,
                             input logic signed [HEAD_W-1:0] ph);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {ph, py, px, prm};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        motion_expect_q.push_back(apply_motion_item(op, prm, px, py, ph));
        if (op != OP_NONE) items_sent++;
    endtask

    task automatic send_random_item();
        send_item(t_opcode'($urandom_range(15)), PARAM_W'($urandom), POS_W'($urandom),
                  POS_W'($urandom), HEAD_W'(rand_heading()));
    endtask

    task automatic report_field(input string name, input longint want_v, input longint got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // check each result transaction against the oldest expected result
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[38:0];
            if (motion_expect_q.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = motion_expect_q.pop_front();
                report_field("tvel_value", longint'(want.tvel_value),
                             longint'(got.tvel_value));
                report_field("tvel_direction", longint'(want.tvel_direction),
                             longint'(got.tvel_direction));
                report_field("tvel_changed", longint'(want.tvel_changed),
                             longint'(got.tvel_changed));
                report_field("rvel_value", longint'(want.rvel_value),
                             longint'(got.rvel_value));
                report_field("rvel_direction", longint'(want.rvel_direction),
                             longint'(got.rvel_direction));
                report_field("rvel_changed", longint'(want.rvel_changed),
                             longint'(got.rvel_changed));
                report_field("move_done", longint'(want.move_done), longint'(got.move_done));
                report_field("padding", 0, longint'(m_axis_tdata[OUT_DATA_W-1]));
            end
        end
        // output ready: long hold-off on request, else random stalls
        if (hold_off_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_off_left--;
        end else if (hold_off_cycles != 0) begin
            m_axis_tready <= 1'b0;
            hold_off_left   = hold_off_cycles - 1;
            hold_off_cycles = 0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("motion_command_relative_terminator regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // every command code but the relative moves, with the velocity extremes, plus an idle pose sample
    task automatic test_velocity_commands();
        send_item(OP_SET_TVEL, 16'sh7FFF, '0, '0, '0);
        send_item(OP_SET_RVEL, 16'sh8000, '0, '0, '0);
        send_item(OP_TRANS_VEL_POS, '0, '0, '0, '0);
        send_item(OP_ROT_VEL_NEG, '0, '0, '0, '0);
        send_item(OP_SET_TVEL, 16'sh8000, '0, '0, '0);
        send_item(OP_SET_RVEL, 16'sh7FFF, '0, '0, '0);
        send_item(OP_TRANS_VEL_NEG, '1, '1, '1, '1);
        send_item(OP_ROT_VEL_POS, '0, '0, '0, '0);
        send_item(OP_POSE, '0, 23'sd1000, 23'sd1000, 18'sd100);
        send_item(OP_TRANS_HALT, '0, '0, '0, '0);
        send_item(OP_ROT_HALT, '0, '0, '0, '0);
        send_item(OP_NONE, 16'sh7FFF, '0, '0, '0);
        send_item(OP_FIND_INDEX, '0, '0, '0, '0);
        send_item(OP_KILL, '0, '0, '0, '0);
    endtask

    // largest goal against opposite position extremes, then a zero goal
    task automatic test_translate_moves();
        send_item(OP_TRANS_REL_POS, 16'sh7FFF, '0, '0, '0);
        send_item(OP_POSE, '0, 23'sh400000, 23'sh3FFFFF, '0);
        send_item(OP_POSE, '0, 23'sh3FFFFF, 23'sh400000, '0);
        send_item(OP_TRANS_REL_NEG, '0, '0, '0, '0);
        send_item(OP_POSE, '0, 23'sd5, 23'sd5, '0);
        send_item(OP_POSE, '0, 23'sd5, 23'sd5, '0);
    endtask

    // scaled goal below 30 degrees, heading extremes and a half-turn wrap
    task automatic test_rotate_moves();
        send_item(OP_ROT_REL_POS, 16'sd85, '0, '0, '0);
        send_item(OP_POSE, '0, '0, '0, 18'sd92160);
        send_item(OP_POSE, '0, '0, '0, -18'sd92160);
        send_item(OP_POSE, '0, '0, '0, -18'sd46080);
    endtask

    // long receiver hold-off while items keep coming, so the input stalls
    task automatic test_output_backpressure();
        send_idle_pct   = 0;
        hold_off_cycles = HOLD_OFF_LEN;
        repeat (16) send_random_item();
    endtask

    // arm one or both terminators, then a run of pose samples moving towards the goal
    task automatic send_move_sequence();
        int kind;
        int steps;
        int dist_mm;
        int turn;
        int span;
        int step_x;
        int step_y;
        int rate;
        int x;
        int y;
        int h;
        kind    = $urandom_range(2);
        dist_mm = 0;
        if (kind != 1) begin
            dist_mm = ($urandom_range(9) < 8) ? rand_span(-20, 3000) : rand_span(-32768, 32767);
            send_item($urandom_range(1) ? OP_TRANS_REL_POS : OP_TRANS_REL_NEG,
                      PARAM_W'(dist_mm), POS_W'($urandom), POS_W'($urandom),
                      HEAD_W'(rand_heading()));
        end
        if (kind != 0) begin
            turn = ($urandom_range(9) < 8) ? rand_span(-200, 200) : rand_span(-32768, 32767);
            send_item($urandom_range(1) ? OP_ROT_REL_POS : OP_ROT_REL_NEG,
                      PARAM_W'(turn), POS_W'($urandom), POS_W'($urandom),
                      HEAD_W'(rand_heading()));
        end
        span   = (dist_mm < 0 ? -dist_mm : dist_mm) / 4 + 20;
        step_x = rand_span(-span, span);
        step_y = rand_span(-span, span);
        rate   = rand_span(-8000, 8000);
        x      = rand_span(POS_MIN, POS_MAX);
        y      = rand_span(POS_MIN, POS_MAX);
        h      = rand_heading();
        steps  = $urandom_range(1, 12);
        repeat (steps + 1) begin
            if ($urandom_range(9) == 0) send_random_item();
            send_item(OP_POSE, PARAM_W'($urandom), POS_W'(x), POS_W'(y), HEAD_W'(h));
            x = x + step_x + rand_span(-8, 8);
            y = y + step_y + rand_span(-8, 8);
            if ($urandom_range(9) == 0)
                h = rand_heading();
            else
                h = h + rate + rand_span(-64, 64);
            if (h > DEG360_Q8)
                h = h - 2 * DEG360_Q8;
            else if (h < -DEG360_Q8)
                h = h + 2 * DEG360_Q8;
        end
    endtask

    // mostly move sequences, the rest unconstrained items
    task automatic test_random_traffic(input int n_items, input int send_pct, input int stall_pct);
        int first;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        first          = items_sent;
        while (items_sent - first < n_items) begin
            if ($urandom_range(99) < 65)
                send_move_sequence();
            else
                send_random_item();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_velocity_commands();
        test_translate_moves();
        test_rotate_moves();
        test_output_backpressure();
        test_random_traffic(PHASE_ITEMS, 0, 0);
        test_random_traffic(PHASE_ITEMS, 81, 0);
        test_random_traffic(PHASE_ITEMS, 0, 81);
        test_random_traffic(PHASE_ITEMS, 27, 27);
        // drain the outstanding results
        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (motion_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("motion_command_relative_terminator regression: pass");
        else
            $display("motion_command_relative_terminator regression: fail");
        $finish;
    end

endmodule

// ===== motion_command_relative_terminator.f =====
+incdir+sv
sv/mcrt_pkg.sv
sv/motion_command_relative_terminator.sv
tb/motion_command_relative_terminator_test.sv
